@@ rtl/core/bmp24_pkg.sv @@
package bmp24_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned DIM_OUT_W = 10;
  localparam int unsigned CFG_DIM_W = 10;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_ERR   = 7;

  // Default width of the internal row counters.
  localparam int unsigned DIM_BITS_DEF = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd1;

  localparam logic [CFG_DIM_W-1:0] MAX_DIM_RESET = 10'd320;

  // Header layout, byte positions of the last byte of each checked field.
  localparam logic [31:0] POS_SIGNATURE = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_INFO_SIZE = 32'd17;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_PLANES    = 32'd27;
  localparam logic [31:0] POS_COMPRESS  = 32'd33;
  localparam logic [31:0] POS_LAST      = 32'd53;
  localparam logic [31:0] HEADER_BYTES  = 32'd54;

  localparam logic [15:0] BM_SIGNATURE = 16'h4d42;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] ONE_PLANE    = 16'd1;

  // Error codes, also the bit index in the error mask.
  localparam logic [ERR_W-1:0] ERR_SIGNATURE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_INFO_SIZE = 3'd1;
  localparam logic [ERR_W-1:0] ERR_PLANES    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_WIDTH     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_HEIGHT    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_COMPRESS  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_OFFSET    = 3'd6;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_PIXEL  = 2'd2,
    MODE_IDLE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_BLUE  = 2'd0,
    PHASE_GREEN = 2'd1,
    PHASE_RED   = 2'd2,
    PHASE_PAD   = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [PIXEL_W-1:0]   pixel;
    logic [DIM_OUT_W-1:0] image_width;
    logic [DIM_OUT_W-1:0] image_height;
    logic [ERR_W-1:0]     error_code;
  } result_t;

endpackage

@@ rtl/core/bmp24_core.sv @@
module bmp24_core import bmp24_pkg::*; #(
  parameter int unsigned DIM_BITS = DIM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [DATA_W-1:0]    data_byte_i,
  input  logic                 first_byte_i,
  input  logic [CFG_DIM_W-1:0] max_width_i,
  input  logic [CFG_DIM_W-1:0] max_height_i,
  output logic                 res_valid_o,
  output result_t              res_o
);

  localparam int unsigned EXT_W = DIM_BITS + DIM_OUT_W;

  mode_e               mode_q, mode_d;
  phase_e              phase_q, phase_d;
  logic [31:0]         pos_q, pos_d;
  logic [31:0]         asm_q, asm_d;
  logic [31:0]         start_q, start_d;
  logic [DIM_BITS-1:0] row_w_q, row_w_d;
  logic [DIM_BITS-1:0] row_h_q, row_h_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [1:0]          pad_q, pad_d;
  logic [1:0]          pad_left_q, pad_left_d;
  logic [4:0]          blue_q, blue_d;
  logic [5:0]          green_q, green_d;
  logic [NUM_ERR-1:0]  err_q, err_d;

  always_comb begin
    mode_e               mode_c;
    phase_e              phase_c;
    logic [31:0]         pos_c;
    logic [31:0]         asm_c;
    logic [31:0]         start_c;
    logic [DIM_BITS-1:0] row_w_c;
    logic [DIM_BITS-1:0] row_h_c;
    logic [DIM_BITS-1:0] col_c;
    logic [DIM_BITS-1:0] col_inc;
    logic [1:0]          pad_c;
    logic [1:0]          pad_left_c;
    logic [4:0]          blue_c;
    logic [5:0]          green_c;
    logic [NUM_ERR-1:0]  err_c;
    logic [15:0]         half;
    logic [ERR_W-1:0]    code;
    logic [EXT_W-1:0]    w_ext;
    logic [EXT_W-1:0]    h_ext;

    // A marked first byte drops all parse state before the byte is used.
    if (first_byte_i) begin
      mode_c     = MODE_HEADER;
      phase_c    = PHASE_BLUE;
      pos_c      = '0;
      asm_c      = '0;
      start_c    = '0;
      row_w_c    = '0;
      row_h_c    = '0;
      col_c      = '0;
      pad_c      = '0;
      pad_left_c = '0;
      blue_c     = '0;
      green_c    = '0;
      err_c      = '0;
    end else begin
      mode_c     = mode_q;
      phase_c    = phase_q;
      pos_c      = pos_q;
      asm_c      = asm_q;
      start_c    = start_q;
      row_w_c    = row_w_q;
      row_h_c    = row_h_q;
      col_c      = col_q;
      pad_c      = pad_q;
      pad_left_c = pad_left_q;
      blue_c     = blue_q;
      green_c    = green_q;
      err_c      = err_q;
    end

    mode_d     = mode_c;
    phase_d    = phase_c;
    pos_d      = pos_c;
    asm_d      = asm_c;
    start_d    = start_c;
    row_w_d    = row_w_c;
    row_h_d    = row_h_c;
    col_d      = col_c;
    pad_d      = pad_c;
    pad_left_d = pad_left_c;
    blue_d     = blue_c;
    green_d    = green_c;
    err_d      = err_c;

    res_valid_o = 1'b0;
    res_o       = '0;
    half        = '0;
    code        = '0;
    col_inc     = '0;
    w_ext       = '0;
    h_ext       = '0;

    case (mode_c)
      MODE_HEADER: begin
        // Little-endian fields: the newest byte enters at the top.
        asm_d = {data_byte_i, asm_c[31:8]};
        half  = asm_d[31:16];
        if (pos_c == POS_SIGNATURE && half != BM_SIGNATURE) begin
          err_d[ERR_SIGNATURE] = 1'b1;
        end
        if (pos_c == POS_OFFSET) begin
          start_d = asm_d;
          if (asm_d < HEADER_BYTES) begin
            err_d[ERR_OFFSET] = 1'b1;
          end
        end
        if (pos_c == POS_INFO_SIZE && asm_d != INFO_SIZE) begin
          err_d[ERR_INFO_SIZE] = 1'b1;
        end
        if (pos_c == POS_WIDTH) begin
          if (asm_d > 32'(max_width_i)) begin
            err_d[ERR_WIDTH] = 1'b1;
          end
          row_w_d = asm_d[DIM_BITS-1:0];
        end
        if (pos_c == POS_HEIGHT) begin
          if (asm_d > 32'(max_height_i)) begin
            err_d[ERR_HEIGHT] = 1'b1;
          end
          row_h_d = asm_d[DIM_BITS-1:0];
        end
        if (pos_c == POS_PLANES && half != ONE_PLANE) begin
          err_d[ERR_PLANES] = 1'b1;
        end
        if (pos_c == POS_COMPRESS && asm_d != 32'd0) begin
          err_d[ERR_COMPRESS] = 1'b1;
        end
        pos_d = pos_c + 32'd1;

        if (pos_c == POS_LAST) begin
          res_valid_o = 1'b1;
          if (err_d != '0) begin
            // The lowest error code present wins.
            for (int i = NUM_ERR - 1; i >= 0; i--) begin
              if (err_d[i]) begin
                code = ERR_W'(i);
              end
            end
            mode_d           = MODE_IDLE;
            res_o.kind       = KIND_REJECT;
            res_o.error_code = code;
          end else begin
            pad_d   = row_w_d[1:0];
            col_d   = '0;
            phase_d = PHASE_BLUE;
            mode_d  = (start_d == HEADER_BYTES) ? MODE_PIXEL : MODE_SKIP;
            w_ext   = EXT_W'(row_w_d);
            h_ext   = EXT_W'(row_h_d);
            res_o.kind         = KIND_ACCEPT;
            res_o.image_width  = w_ext[DIM_OUT_W-1:0];
            res_o.image_height = h_ext[DIM_OUT_W-1:0];
          end
        end
      end

      MODE_SKIP: begin
        pos_d = pos_c + 32'd1;
        if (pos_d >= start_c) begin
          mode_d = MODE_PIXEL;
        end
      end

      MODE_PIXEL: begin
        case (phase_c)
          PHASE_BLUE: begin
            blue_d  = data_byte_i[7:3];
            phase_d = PHASE_GREEN;
          end
          PHASE_GREEN: begin
            green_d = data_byte_i[7:2];
            phase_d = PHASE_RED;
          end
          PHASE_RED: begin
            phase_d = PHASE_BLUE;
            // Rows whose byte length is a multiple of four carry no padding
            // and need no column count.
            if (pad_c != 2'd0) begin
              col_inc = col_c + DIM_BITS'(1);
              if (col_inc >= row_w_c) begin
                col_d      = '0;
                pad_left_d = pad_c;
                phase_d    = PHASE_PAD;
              end else begin
                col_d = col_inc;
              end
            end
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PIXEL;
            res_o.pixel = {data_byte_i[7:3], green_c, blue_c};
          end
          default: begin
            pad_left_d = pad_left_c - 2'd1;
            if (pad_left_d == 2'd0) begin
              phase_d = PHASE_BLUE;
            end
          end
        endcase
      end

      default: begin
        // Rejected header: wait for the next file.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HEADER;
      phase_q    <= PHASE_BLUE;
      pos_q      <= '0;
      asm_q      <= '0;
      start_q    <= '0;
      row_w_q    <= '0;
      row_h_q    <= '0;
      col_q      <= '0;
      pad_q      <= '0;
      pad_left_q <= '0;
      blue_q     <= '0;
      green_q    <= '0;
      err_q      <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      asm_q      <= asm_d;
      start_q    <= start_d;
      row_w_q    <= row_w_d;
      row_h_q    <= row_h_d;
      col_q      <= col_d;
      pad_q      <= pad_d;
      pad_left_q <= pad_left_d;
      blue_q     <= blue_d;
      green_q    <= green_d;
      err_q      <= err_d;
    end
  end

endmodule

@@ rtl/core/bmp24_stream_to_rgb565_unit.sv @@
// BMP 24-bit byte stream to RGB565 converter.
//
// The input channel carries one file byte per word, with first_byte_i marking
// byte zero of a new file. The block parses the 54-byte header, and with the
// last header byte it emits one word: header accepted (with width and height)
// or header rejected (with the lowest error code found). After an accepted
// header it skips to the pixel data offset, emits one RGB565 word for each
// blue, green, red byte triple and drops the row padding bytes.
// The configuration channel writes max_width (index 0) and max_height
// (index 1); it is always ready and should only be used while the block idles.
//
// Throughput is one byte per cycle while results are taken. An accepted byte
// is held in the input register and then processed into the result register,
// where its result waits until the receiver takes it. If the receiver stalls,
// the result register holds its word and the input register fills; input
// ready then drops until the result is taken. Reset sets both limits to 320
// and starts parsing at header byte zero, even without a marked first byte.
module bmp24_stream_to_rgb565_unit import bmp24_pkg::*; #(
  parameter int unsigned DIM_BITS = DIM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DATA_W-1:0]    data_byte_i,
  input  logic                 first_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [PIXEL_W-1:0]   pixel_o,
  output logic [DIM_OUT_W-1:0] image_width_o,
  output logic [DIM_OUT_W-1:0] image_height_o,
  output logic [ERR_W-1:0]     error_code_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i
);

  logic                 in_valid_q;
  logic [DATA_W-1:0]    data_q;
  logic                 first_q;
  logic                 out_valid_q;
  result_t              out_q;
  logic [CFG_DIM_W-1:0] max_width_q;
  logic [CFG_DIM_W-1:0] max_height_q;
  logic                 step;
  logic                 res_valid;
  result_t              res;

  // The held byte is processed once the result register is free or is being
  // emptied in this cycle.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q  <= data_byte_i;
      first_q <= first_byte_i;
    end
  end

  bmp24_core #(
    .DIM_BITS(DIM_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_q),
    .first_byte_i(first_q),
    .max_width_i (max_width_q),
    .max_height_i(max_height_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign pixel_o        = out_q.pixel;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;
  assign error_code_o   = out_q.error_code;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q  <= MAX_DIM_RESET;
      max_height_q <= MAX_DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_WIDTH: begin
          max_width_q <= cfg_data_i;
        end
        CFG_MAX_HEIGHT: begin
          max_height_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sim/bmp24_checker.sv @@
module bmp24_checker import bmp24_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [DATA_W-1:0]    data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [PIXEL_W-1:0]   pixel_i,
  input  logic [DIM_OUT_W-1:0] image_width_i,
  input  logic [DIM_OUT_W-1:0] image_height_i,
  input  logic [ERR_W-1:0]     error_code_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DIM_W-1:0] cfg_data_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int unsigned DIM = DIM_BITS_DEF;

  // Shadow copy of the parser state.
  mode_e                par_mode;
  logic [31:0]          par_pos;
  logic [31:0]          par_word;
  logic [31:0]          par_start;
  logic [DIM-1:0]       par_width;
  logic [DIM-1:0]       par_height;
  logic [DIM-1:0]       par_col;
  logic [1:0]           par_pad;
  logic [1:0]           par_pad_left;
  phase_e               par_phase;
  logic [4:0]           par_blue;
  logic [5:0]           par_green;
  logic [NUM_ERR-1:0]   par_faults;
  logic [CFG_DIM_W-1:0] lim_width;
  logic [CFG_DIM_W-1:0] lim_height;

  result_t predicted_words[$];
  int      mismatches;

  function automatic void rewind_parser();
    par_mode     = MODE_HEADER;
    par_pos      = '0;
    par_word     = '0;
    par_start    = '0;
    par_width    = '0;
    par_height   = '0;
    par_col      = '0;
    par_pad      = '0;
    par_pad_left = '0;
    par_phase    = PHASE_BLUE;
    par_blue     = '0;
    par_green    = '0;
    par_faults   = '0;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when the byte yields a word.
  function automatic bit decode_byte(input logic [DATA_W-1:0] b, input logic first,
                                     output result_t word);
    logic [31:0] pos;
    logic [15:0] half;
    bit          emit;
    emit = 1'b0;
    word = '0;
    if (first) rewind_parser();
    case (par_mode)
      MODE_HEADER: begin
        pos      = par_pos;
        par_word = {b, par_word[31:8]};
        half     = par_word[31:16];
        if (pos == POS_SIGNATURE && half != BM_SIGNATURE) par_faults[ERR_SIGNATURE] = 1'b1;
        if (pos == POS_OFFSET) begin
          par_start = par_word;
          if (par_word < HEADER_BYTES) par_faults[ERR_OFFSET] = 1'b1;
        end
        if (pos == POS_INFO_SIZE && par_word != INFO_SIZE) par_faults[ERR_INFO_SIZE] = 1'b1;
        if (pos == POS_WIDTH) begin
          if (par_word > 32'(lim_width)) par_faults[ERR_WIDTH] = 1'b1;
          par_width = par_word[DIM-1:0];
        end
        if (pos == POS_HEIGHT) begin
          if (par_word > 32'(lim_height)) par_faults[ERR_HEIGHT] = 1'b1;
          par_height = par_word[DIM-1:0];
        end
        if (pos == POS_PLANES && half != ONE_PLANE) par_faults[ERR_PLANES] = 1'b1;
        if (pos == POS_COMPRESS && par_word != '0) par_faults[ERR_COMPRESS] = 1'b1;
        par_pos = pos + 1;
        if (pos == POS_LAST) begin
          emit = 1'b1;
          if (par_faults != '0) begin
            // The lowest fault wins, so scan from the top down.
            word.kind = KIND_REJECT;
            for (int i = NUM_ERR - 1; i >= 0; i--) begin
              if (par_faults[i]) word.error_code = ERR_W'(i);
            end
            par_mode = MODE_IDLE;
          end else begin
            par_pad           = par_width[1:0];
            par_col           = '0;
            par_phase         = PHASE_BLUE;
            par_mode          = (par_start == HEADER_BYTES) ? MODE_PIXEL : MODE_SKIP;
            word.kind         = KIND_ACCEPT;
            word.image_width  = par_width;
            word.image_height = par_height;
          end
        end
      end
      MODE_SKIP: begin
        par_pos = par_pos + 1;
        if (par_pos >= par_start) par_mode = MODE_PIXEL;
      end
      MODE_PIXEL: begin
        case (par_phase)
          PHASE_BLUE: begin
            par_blue  = b[7:3];
            par_phase = PHASE_GREEN;
          end
          PHASE_GREEN: begin
            par_green = b[7:2];
            par_phase = PHASE_RED;
          end
          PHASE_RED: begin
            par_phase = PHASE_BLUE;
            if (par_pad != '0) begin
              par_col = par_col + 1'b1;
              if (par_col >= par_width) begin
                par_col      = '0;
                par_pad_left = par_pad;
                par_phase    = PHASE_PAD;
              end
            end
            word.kind  = KIND_PIXEL;
            word.pixel = {b[7:3], par_green, par_blue};
            emit       = 1'b1;
          end
          default: begin
            par_pad_left = par_pad_left - 1'b1;
            if (par_pad_left == '0) par_phase = PHASE_BLUE;
          end
        endcase
      end
      default: ;
    endcase
    return emit;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t oldest;
    result_t fresh;
    if (!rst_ni) begin
      rewind_parser();
      lim_width  = MAX_DIM_RESET;
      lim_height = MAX_DIM_RESET;
      predicted_words.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // A word leaving now stems from earlier bytes, so check it first.
      if (out_valid_i && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          $error("unexpected result word, kind %0d", kind_i);
          mismatches++;
        end else begin
          oldest = predicted_words.pop_front();
          compare_field("kind", 16'(oldest.kind), 16'(kind_i));
          compare_field("pixel", oldest.pixel, pixel_i);
          compare_field("image_width", 16'(oldest.image_width), 16'(image_width_i));
          compare_field("image_height", 16'(oldest.image_height), 16'(image_height_i));
          compare_field("error_code", 16'(oldest.error_code), 16'(error_code_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_WIDTH:  lim_width  = cfg_data_i;
          CFG_MAX_HEIGHT: lim_height = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_byte(data_byte_i, first_byte_i, fresh)) predicted_words.push_back(fresh);
      end
      pending_o    <= predicted_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench for the BMP byte stream to RGB565 converter.
//
// This top only makes stimulus and gives the verdict. The checker beside the
// block watches all three channels, keeps its own copy of the parser state,
// predicts every result word and compares it field by field.
//
// The stimulus is built from whole BMP files: a 54-byte header with the
// checked fields set on purpose and the rest random, then skip bytes up to
// the data offset and rows of pixel triples with their padding. A directed
// part covers each error code, several faults at once, the width and height
// limits, widths with every padding, an unmarked file after reset, restarts
// in the middle of a header, of a skip and of pixel data, and bytes that are
// ignored after a reject. A random part follows in phases with different
// limits; most files there are well formed, the rest are faulty headers,
// broken headers and noise.
module tb_top import bmp24_pkg::*; ();

  // Generous bound on the whole run, in clock cycles.
  localparam int RUN_LIMIT = 1000000;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  // Random bytes wanted in each random phase.
  localparam int PHASE_BYTES = 50;

  typedef struct {
    logic [15:0] sig;
    logic [31:0] offset;
    logic [31:0] info;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [31:0] comp;
  } bmp_head_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [DATA_W-1:0]    data_byte   = '0;
  logic                 first_byte  = 1'b0;
  logic                 out_ready   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DIM_W-1:0] cfg_data    = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  logic [1:0]           kind;
  logic [PIXEL_W-1:0]   pixel;
  logic [DIM_OUT_W-1:0] image_width;
  logic [DIM_OUT_W-1:0] image_height;
  logic [ERR_W-1:0]     error_code;

  int pending_words;
  int fail_count;

  // Once set, neither side idles any more.
  bit calm = 1'b0;
  // Limits as last written, used to aim widths and heights at the edges.
  logic [CFG_DIM_W-1:0] lim_w = MAX_DIM_RESET;
  logic [CFG_DIM_W-1:0] lim_h = MAX_DIM_RESET;
  int byte_count = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  bmp24_stream_to_rgb565_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .first_byte_i   (first_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .pixel_o        (pixel),
    .image_width_o  (image_width),
    .image_height_o (image_height),
    .error_code_o   (error_code),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  bmp24_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .first_byte_i   (first_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .pixel_i        (pixel),
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .error_code_i   (error_code),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending_words),
    .fail_count_o   (fail_count)
  );

  // Sends one byte word. Valid stays high afterwards so that back-to-back
  // words never see valid dropped and raised in the same time step; it is
  // only lowered for an idle burst or when the stream pauses.
  task automatic push_byte(input logic [DATA_W-1:0] b, input logic mark);
    if (!calm && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    byte_count++;
  endtask

  // A header that passes every check at the given geometry and offset.
  function automatic bmp_head_t good_head(input logic [31:0] w, input logic [31:0] h,
                                          input logic [31:0] off);
    bmp_head_t hd;
    hd.sig    = BM_SIGNATURE;
    hd.offset = off;
    hd.info   = INFO_SIZE;
    hd.width  = w;
    hd.height = h;
    hd.planes = ONE_PLANE;
    hd.comp   = '0;
    return hd;
  endfunction

  // Breaks exactly the field behind one error code. An odd xor mask can
  // never leave a field at its required value.
  function automatic bmp_head_t spoil(input bmp_head_t hd, input logic [ERR_W-1:0] code);
    case (code)
      ERR_SIGNATURE: hd.sig    = hd.sig ^ 16'($urandom | 1);
      ERR_INFO_SIZE: hd.info   = hd.info ^ ($urandom | 1);
      ERR_PLANES:    hd.planes = hd.planes ^ 16'($urandom | 1);
      ERR_WIDTH:     hd.width  = $urandom_range(0, 1) ? 32'(lim_w) + $urandom_range(1, 4)
                                                     : ($urandom | 32'h8000_0000);
      // A negative height reads as a huge unsigned one.
      ERR_HEIGHT:    hd.height = $urandom_range(0, 1) ? 32'(lim_h) + $urandom_range(1, 4)
                                                     : ($urandom | 32'h8000_0000);
      ERR_COMPRESS:  hd.comp   = $urandom | 1;
      ERR_OFFSET:    hd.offset = $urandom_range(0, HEADER_BYTES - 1);
      default: ;
    endcase
    return hd;
  endfunction

  // Sends the first count bytes of a header; the unchecked fields are random.
  task automatic send_head(input bmp_head_t hd, input bit mark, input int count);
    logic [7:0] hb [int'(HEADER_BYTES)];
    foreach (hb[i]) hb[i] = 8'($urandom);
    hb[POS_SIGNATURE - 1] = hd.sig[7:0];
    hb[POS_SIGNATURE]     = hd.sig[15:8];
    hb[POS_PLANES - 1]    = hd.planes[7:0];
    hb[POS_PLANES]        = hd.planes[15:8];
    for (int k = 0; k < 4; k++) begin
      hb[POS_OFFSET - 3 + k]    = hd.offset[8*k +: 8];
      hb[POS_INFO_SIZE - 3 + k] = hd.info[8*k +: 8];
      hb[POS_WIDTH - 3 + k]     = hd.width[8*k +: 8];
      hb[POS_HEIGHT - 3 + k]    = hd.height[8*k +: 8];
      hb[POS_COMPRESS - 3 + k]  = hd.comp[8*k +: 8];
    end
    for (int i = 0; i < count; i++) push_byte(hb[i], mark && i == 0);
  endtask

  // Skip bytes up to the offset, full rows with padding, then loose bytes.
  task automatic send_body(input int w, input int off, input int rows, input int extra);
    repeat (off - int'(HEADER_BYTES)) push_byte(8'($urandom), 1'b0);
    repeat (rows) begin
      repeat (w * 3 + w % 4) push_byte(8'($urandom), 1'b0);
    end
    repeat (extra) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_noise(input int n, input bit marks);
    repeat (n) push_byte(8'($urandom), marks && $urandom_range(0, 7) == 0);
  endtask

  // Writes both limits and then the spare index, valid held high throughout.
  task automatic set_limits(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DIM_W'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lim_w = w;
    lim_h = h;
  endtask

  // Stops sending and waits until every predicted word has come out. Skip
  // and padding bytes make no word, so it keeps waiting after that to let the
  // two-stage pipeline run empty before anything is reconfigured.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random file: mostly well formed, sometimes faulty, broken or noise.
  task automatic random_file();
    bmp_head_t hd;
    int pick;
    int w;
    int off;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) w = lim_w;
    else w = $urandom_range(0, (lim_w < 6) ? lim_w : 6);
    off = $urandom_range(0, 1) ? int'(HEADER_BYTES) : $urandom_range(55, 60);
    hd = good_head(w, $urandom_range(0, lim_h), off);
    case (pick)
      0: send_noise($urandom_range(4, 30), 1'b1);
      1: begin
        hd = spoil(hd, ERR_W'($urandom_range(0, NUM_ERR - 1)));
        if ($urandom_range(0, 2) == 0) hd = spoil(hd, ERR_W'($urandom_range(0, NUM_ERR - 1)));
        send_head(hd, 1'b1, HEADER_BYTES);
        // These bytes fall on a rejected file and are dropped.
        send_noise($urandom_range(0, 5), 1'b0);
      end
      2: send_head(hd, 1'b1, $urandom_range(1, POS_LAST));
      default: begin
        send_head(hd, $urandom_range(0, 15) != 0, HEADER_BYTES);
        // Wide rows would be long; a few pixels show the geometry was taken.
        if (w > 6) send_body(w, off, 0, $urandom_range(3, 9));
        else send_body(w, off, $urandom_range(1, 3), $urandom_range(0, 4));
      end
    endcase
  endtask

  // The receiver stalls in random bursts until the final phase.
  initial begin : receiver
    @(posedge clk);
    while (rst_n == 1'b0) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DIM_W-1:0] w_lim;
    logic [CFG_DIM_W-1:0] h_lim;
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Straight after reset the parser starts at byte zero without a mark.
    // Width 3 gives three padding bytes; the loose triple after the last row
    // shows that pixels keep coming past the stated height.
    send_head(good_head(3, 2, HEADER_BYTES), 1'b0, HEADER_BYTES);
    send_body(3, HEADER_BYTES, 2, 3);
    // Width zero is accepted and has no padding; the offset forces two skips.
    send_head(good_head(0, 0, 56), 1'b1, HEADER_BYTES);
    send_body(0, 56, 0, 9);
    send_head(good_head(1, 1, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(1, HEADER_BYTES, 2, 0);
    send_head(good_head(2, 5, 55), 1'b1, HEADER_BYTES);
    send_body(2, 55, 2, 2);
    send_head(good_head(4, 3, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(4, HEADER_BYTES, 1, 3);
    // Both dimensions exactly at the reset limits.
    send_head(good_head(lim_w, lim_h, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(0, HEADER_BYTES, 0, 6);

    // Each fault alone; the bytes after a reject are ignored.
    for (int c = 0; c < NUM_ERR; c++) begin
      send_head(spoil(good_head(4, 4, HEADER_BYTES), ERR_W'(c)), 1'b1, HEADER_BYTES);
      send_noise(3, 1'b0);
    end
    // Several faults at once: the lowest code is reported.
    send_head(spoil(spoil(spoil(good_head(5, 5, HEADER_BYTES), ERR_OFFSET), ERR_COMPRESS),
                    ERR_SIGNATURE), 1'b1, HEADER_BYTES);
    send_head(spoil(spoil(spoil(good_head(5, 5, HEADER_BYTES), ERR_HEIGHT), ERR_WIDTH),
                    ERR_PLANES), 1'b1, HEADER_BYTES);
    // A clean but unmarked header after a reject is ignored as a whole.
    send_head(good_head(2, 2, HEADER_BYTES), 1'b0, HEADER_BYTES);
    // Restart in the middle of a header, of a skip and of pixel data.
    send_head(good_head(2, 2, HEADER_BYTES), 1'b1, 20);
    send_head(good_head(2, 1, 60), 1'b1, HEADER_BYTES);
    send_noise(2, 1'b0);
    send_head(good_head(3, 1, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(3, HEADER_BYTES, 0, 7);

    // Smallest limits: one pixel passes, two are too many either way.
    settle();
    set_limits(10'd1, 10'd1);
    send_head(good_head(1, 1, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(1, HEADER_BYTES, 1, 0);
    send_head(good_head(2, 1, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_head(good_head(1, 2, HEADER_BYTES), 1'b1, HEADER_BYTES);
    // Largest limits: 1023 passes, 1024 does not.
    settle();
    set_limits(10'd1023, 10'd1023);
    send_head(good_head(1023, 1023, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_body(0, HEADER_BYTES, 0, 6);
    send_head(good_head(1024, 7, HEADER_BYTES), 1'b1, HEADER_BYTES);
    send_head(good_head(7, 1024, HEADER_BYTES), 1'b1, HEADER_BYTES);

    // Random phases under different limits. Every switch waits for all
    // results first. The final phase runs with no idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          w_lim = MAX_DIM_RESET;
          h_lim = MAX_DIM_RESET;
        end
        1: begin
          w_lim = 10'd1;
          h_lim = 10'd1;
        end
        2: begin
          w_lim = 10'd1023;
          h_lim = 10'd1023;
        end
        default: begin
          w_lim = CFG_DIM_W'($urandom_range(1, 1023));
          h_lim = CFG_DIM_W'($urandom_range(1, 1023));
        end
      endcase
      settle();
      if (ph == 4) calm = 1'b1;
      set_limits(w_lim, h_lim);
      goal = byte_count + PHASE_BYTES;
      while (byte_count < goal) random_file();
    end

    settle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
